// ----- hw/rtl/vapn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vapn_pkg
// Shared types, codes and helpers for the visibility power normaliser.
// ----------------------------------------------------------------------------
package vapn_pkg;

   localparam int REQ_DATA_W  = 112;
   localparam int RSP_DATA_W  = 64;
   localparam int KIND_W      = 3;
   localparam int STATUS_W    = 2;
   localparam int SAMPLE_W    = 32;
   localparam int SUM_W       = 48;
   localparam int DIVD_W      = 49;
   localparam int DIVS_W      = 64;
   localparam int ROOT_IN_W   = 64;
   localparam int POWER_W     = 32;

   localparam logic [POWER_W-1:0] ONE_Q16 = 32'h0001_0000;

   localparam logic [7:0] POL_L = 8'h4C;
   localparam logic [7:0] POL_R = 8'h52;
   localparam logic [7:0] POL_X = 8'h58;
   localparam logic [7:0] POL_Y = 8'h59;

   typedef enum logic [KIND_W-1:0] {
      KIND_MAP_RESET   = 3'd0,
      KIND_MAP_ENTRY   = 3'd1,
      KIND_POWER_CLEAR = 3'd2,
      KIND_SURVEY      = 3'd3,
      KIND_SCALE       = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_NO_POWER = 2'd1,
      STAT_BAD_POL  = 2'd2,
      STAT_BAD_ANT  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_FACT_CHECK,
      ST_FACT_MUL,
      ST_FACT_START,
      ST_FACT_DIV,
      ST_MEAN_START,
      ST_MEAN_DIV,
      ST_SQRT,
      ST_SCALE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic map_reset;
      logic map_write;
      logic power_clear;
      logic sweep;
      logic accumulate;
      logic fact_check;
      logic fact_mul;
      logic div_start;
      logic div_sel_mean;
      logic fact_store;
      logic sqrt_start;
      logic surv_write;
      logic scale_mul;
      logic emit;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     last;
      logic     record_open;
      logic     fact_ok;
      logic     sum_pos;
      logic     sweep_done;
      logic     div_done;
      logic     sqrt_done;
      logic     out_free;
   } stat_type;

   // {valid, code}
   function automatic logic [2:0] pol_decode(input logic [7:0] c);
      logic [2:0] r;
      if (c == POL_L) r = 3'b100;
      else if (c == POL_R) r = 3'b101;
      else if (c == POL_X) r = 3'b110;
      else if (c == POL_Y) r = 3'b111;
      else r = 3'b000;
      return r;
   endfunction

endpackage

// ----- hw/rtl/visibility_auto_power_normalizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// visibility_auto_power_normalizer
// Auto-power survey and normalisation of correlator visibility points.
//
//   channel   direction  tdata                        tuser    tlast
//   req_      in         baseline..imag_part (112b)   kind     last_point
//   rsp_      out        scaled_real, scaled_imag     status   last_of_record
//
// One request in flight. Map requests, power clears and survey points pass the
// decode state; a point of an open scale record then takes the scale and output
// states. Opening a scale record checks both table entries and, when both hold
// power, divides 2^48 by their product. A survey record's last point runs the
// divider and the square root, or neither when the sum is not positive.
// After reset and after a power clear the table is swept, one entry a cycle,
// over all ANTENNAS*FREQS*4 entries, with req_tready low.
// A stalled result holds in the output register; the next scale point waits.
// ----------------------------------------------------------------------------
module visibility_auto_power_normalizer #(
   parameter int ANTENNAS   = 32,
   parameter int FREQS      = 32,
   parameter int MAX_POINTS = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // baseline, ref_pol, rem_pol, chan_index, partner_chan_index, real_part,
   // imag_part, zero pad
   input  logic [vapn_pkg::REQ_DATA_W-1:0]    req_tdata,
   // kind
   input  logic [vapn_pkg::KIND_W-1:0]        req_tuser,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // scaled_real, scaled_imag
   output logic [vapn_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status
   output logic [vapn_pkg::STATUS_W-1:0]      rsp_tuser,
   output logic                               rsp_tlast
);
   import vapn_pkg::*;

   cmd_type             cmd;
   stat_type            stat;
   logic [SAMPLE_W-1:0] rsp_real, rsp_imag;

   vapn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   vapn_datapath #(
      .ANTENNAS   (ANTENNAS),
      .FREQS      (FREQS),
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_data   (req_tdata),
      .req_kind   (req_tuser),
      .req_last   (req_tlast),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_real   (rsp_real),
      .rsp_imag   (rsp_imag),
      .rsp_status (rsp_tuser),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {rsp_imag, rsp_real};

endmodule

// ----- hw/rtl/vapn_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vapn_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vapn_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [vapn_pkg::DIVD_W-1:0]   dividend,
   input  logic [vapn_pkg::DIVS_W-1:0]   divisor,
   output logic [vapn_pkg::DIVD_W-1:0]   quotient,
   output logic                          done
);
   import vapn_pkg::*;

   localparam int CNT_W = $clog2(DIVD_W);

   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVS_W-1:0] dsr_ff;
   logic [DIVD_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff, done_ff;
   logic [DIVS_W:0]   shifted, trial;

   always_comb begin
      shifted = {rem_ff, q_ff[DIVD_W-1]};
      trial   = shifted - {1'b0, dsr_ff};
      if (!trial[DIVS_W]) begin
         rem_in = trial[DIVS_W-1:0];
         q_in   = {q_ff[DIVD_W-2:0], 1'b1};
      end else begin
         rem_in = shifted[DIVS_W-1:0];
         q_in   = {q_ff[DIVD_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIVD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dsr_ff <= divisor;
         q_ff   <= dividend;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
   end

   assign quotient = q_ff;
   assign done     = done_ff;

endmodule

// ----- hw/rtl/vapn_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vapn_sqrt
// Integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module vapn_sqrt (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [vapn_pkg::ROOT_IN_W-1:0]   radicand,
   output logic [vapn_pkg::POWER_W-1:0]     root,
   output logic                             done
);
   import vapn_pkg::*;

   localparam int STEPS = ROOT_IN_W / 2;
   localparam int CNT_W = $clog2(STEPS);

   logic [ROOT_IN_W-1:0] v_ff, res_ff, bit_ff;
   logic [ROOT_IN_W-1:0] v_in, res_in, sum;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 busy_ff, done_ff;

   always_comb begin
      sum = res_ff + bit_ff;
      if (v_ff >= sum) begin
         v_in   = v_ff - sum;
         res_in = (res_ff >> 1) + bit_ff;
      end else begin
         v_in   = v_ff;
         res_in = res_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff   <= radicand;
         res_ff <= '0;
         bit_ff <= {2'b01, {(ROOT_IN_W-2){1'b0}}};
      end else if (busy_ff) begin
         v_ff   <= v_in;
         res_ff <= res_in;
         bit_ff <= bit_ff >> 2;
      end
   end

   assign root = res_ff[POWER_W-1:0];
   assign done = done_ff;

endmodule

// ----- hw/rtl/vapn_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vapn_datapath
// Request registers, frequency map, power table, accumulator and scaling.
// ----------------------------------------------------------------------------
module vapn_datapath #(
   parameter int ANTENNAS   = 32,
   parameter int FREQS      = 32,
   parameter int MAX_POINTS = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  vapn_pkg::cmd_type                  cmd,
   output vapn_pkg::stat_type                 stat,
   input  logic [vapn_pkg::REQ_DATA_W-1:0]    req_data,
   input  logic [vapn_pkg::KIND_W-1:0]        req_kind,
   input  logic                               req_last,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [vapn_pkg::SAMPLE_W-1:0]      rsp_real,
   output logic [vapn_pkg::SAMPLE_W-1:0]      rsp_imag,
   output logic [vapn_pkg::STATUS_W-1:0]      rsp_status,
   output logic                               rsp_last
);
   import vapn_pkg::*;

   localparam int TABLE_SIZE = ANTENNAS * FREQS * 4;
   localparam int AW         = $clog2(TABLE_SIZE);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   // request registers
   logic [KIND_W-1:0]   kind_ff;
   logic                last_ff;
   logic [15:0]         baseline_ff;
   logic [7:0]          rpol_ff, mpol_ff;
   logic [4:0]          fidx_ff, pidx_ff;
   logic [SAMPLE_W-1:0] re_ff, im_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff     <= req_kind;
         last_ff     <= req_last;
         baseline_ff <= req_data[15:0];
         rpol_ff     <= req_data[23:16];
         mpol_ff     <= req_data[31:24];
         fidx_ff     <= req_data[36:32];
         pidx_ff     <= req_data[41:37];
         re_ff       <= req_data[73:42];
         im_ff       <= req_data[105:74];
      end
   end

   // frequency map
   logic [4:0] fmap_ff [32];

   always_ff @(posedge clock) begin
      if (reset || cmd.map_reset) begin
         for (int i = 0; i < 32; i++) fmap_ff[i] <= 5'(i);
      end else if (cmd.map_write) begin
         if (fidx_ff < pidx_ff) fmap_ff[pidx_ff] <= fidx_ff;
         else if (pidx_ff < fidx_ff) fmap_ff[fidx_ff] <= pidx_ff;
      end
   end

   // slot addressing
   logic [4:0]  fmapped;
   logic [7:0]  ab_ref, ab_rem;
   logic [2:0]  pc_ref, pc_rem;
   logic        ref_in, rem_in, f_in;
   logic [31:0] slot_ref_w, slot_rem_w;
   logic [AW-1:0] slot_ref, slot_rem;

   always_comb begin
      fmapped    = fmap_ff[fidx_ff];
      ab_ref     = baseline_ff[15:8];
      ab_rem     = baseline_ff[7:0];
      pc_ref     = pol_decode(rpol_ff);
      pc_rem     = pol_decode(mpol_ff);
      f_in       = 32'(fmapped) < 32'(FREQS);
      ref_in     = (ab_ref != 8'd0) && (32'(ab_ref) <= 32'(ANTENNAS)) && f_in;
      rem_in     = (ab_rem != 8'd0) && (32'(ab_rem) <= 32'(ANTENNAS)) && f_in;
      slot_ref_w = ((32'(ab_ref) - 32'd1) * 32'(FREQS) + 32'(fmapped)) * 32'd4
                   + 32'(pc_ref[1:0]);
      slot_rem_w = ((32'(ab_rem) - 32'd1) * 32'(FREQS) + 32'(fmapped)) * 32'd4
                   + 32'(pc_rem[1:0]);
      slot_ref   = slot_ref_w[AW-1:0];
      slot_rem   = slot_rem_w[AW-1:0];
   end

   // accumulator
   logic signed [SUM_W-1:0] sum_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic                    sum_pos;

   always_ff @(posedge clock) begin
      if (reset || cmd.power_clear || cmd.surv_write) begin
         sum_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.accumulate && (cnt_ff < CNT_W'(MAX_POINTS))) begin
         sum_ff <= sum_ff + SUM_W'($signed(re_ff));
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign sum_pos = !sum_ff[SUM_W-1] && (sum_ff != '0);

   // shared divider and square root
   logic [DIVD_W-1:0] div_dvd, div_q;
   logic [DIVS_W-1:0] div_dsr;
   logic              div_done;
   logic [DIVS_W-1:0] prod_ff;
   logic [POWER_W-1:0] root;
   logic              sqrt_done;

   assign div_dvd = cmd.div_sel_mean ? {2'b00, sum_ff[SUM_W-2:0]}
                                     : {1'b1, {(DIVD_W-1){1'b0}}};
   assign div_dsr = cmd.div_sel_mean ? DIVS_W'(cnt_ff) : prod_ff;

   vapn_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .quotient (div_q),
      .done     (div_done)
   );

   vapn_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand ({div_q[SUM_W-1:0], 16'h0000}),
      .root     (root),
      .done     (sqrt_done)
   );

   // power table, valid bit on top
   logic [POWER_W:0]  ptab_mem [TABLE_SIZE];
   logic [POWER_W:0]  rd_ref_ff, rd_rem_ff;
   logic [AW-1:0]     sweep_ff;
   logic              surv_ok, mem_we;
   logic [AW-1:0]     mem_wa;
   logic [POWER_W:0]  mem_wd;

   assign surv_ok = (ab_ref == ab_rem) && (rpol_ff == mpol_ff) && pc_ref[2] && ref_in;
   assign mem_we  = cmd.sweep || (cmd.surv_write && surv_ok);
   assign mem_wa  = cmd.sweep ? sweep_ff : slot_ref;
   assign mem_wd  = cmd.sweep ? '0 : {1'b1, (sum_pos ? root : '0)};

   always_ff @(posedge clock) begin
      if (mem_we) ptab_mem[mem_wa] <= mem_wd;
      rd_ref_ff <= ptab_mem[slot_ref];
      rd_rem_ff <= ptab_mem[slot_rem];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.power_clear) sweep_ff <= '0;
      else if (cmd.sweep) sweep_ff <= sweep_ff + 1'b1;
   end

   // record factor
   logic [POWER_W-1:0] pr, pm;
   logic               vr, vm;
   status_type         chk_status;
   logic               open_ff;
   logic [POWER_W-1:0] factor_ff;
   status_type         status_ff;

   always_comb begin
      pr = rd_ref_ff[POWER_W-1:0];
      pm = rd_rem_ff[POWER_W-1:0];
      vr = rd_ref_ff[POWER_W];
      vm = rd_rem_ff[POWER_W];
      priority if (!pc_ref[2] || !pc_rem[2]) chk_status = STAT_BAD_POL;
      else if (!ref_in || !rem_in) chk_status = STAT_BAD_ANT;
      else if (!vr || !vm || (pr == '0) || (pm == '0)) chk_status = STAT_NO_POWER;
      else chk_status = STAT_OK;
   end

   always_ff @(posedge clock) begin
      if (cmd.fact_mul) prod_ff <= DIVS_W'(pr) * DIVS_W'(pm);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff   <= 1'b0;
         factor_ff <= '0;
         status_ff <= STAT_OK;
      end else begin
         if (cmd.power_clear) open_ff <= 1'b0;
         else if (cmd.emit) open_ff <= !last_ff;
         if (cmd.fact_check) begin
            status_ff <= chk_status;
            factor_ff <= ONE_Q16;
         end else if (cmd.fact_store) begin
            factor_ff <= (div_q[DIVD_W-1:POWER_W] != '0) ? '1 : div_q[POWER_W-1:0];
         end
      end
   end

   // scaling
   logic signed [2*SAMPLE_W:0] mre_ff, mim_ff;

   always_ff @(posedge clock) begin
      if (cmd.scale_mul) begin
         mre_ff <= $signed(re_ff) * $signed({1'b0, factor_ff});
         mim_ff <= $signed(im_ff) * $signed({1'b0, factor_ff});
      end
   end

   function automatic logic [SAMPLE_W-1:0] fix_sat(input logic signed [2*SAMPLE_W:0] p);
      logic signed [2*SAMPLE_W:0] b;
      logic signed [2*SAMPLE_W-16:0] q;
      logic [SAMPLE_W-1:0] r;
      b = p + (p[2*SAMPLE_W] ? 65'sd65535 : 65'sd0);
      q = b[2*SAMPLE_W:16];
      if (q > $signed({18'h00000, 31'h7FFF_FFFF})) r = 32'h7FFF_FFFF;
      else if (q < $signed({18'h3FFFF, 31'h0000_0000})) r = 32'h8000_0000;
      else r = q[SAMPLE_W-1:0];
      return r;
   endfunction

   // result register
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_real_ff, rsp_imag_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.emit) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_real_ff   <= fix_sat(mre_ff);
         rsp_imag_ff   <= fix_sat(mim_ff);
         rsp_status_ff <= status_ff;
         rsp_last_ff   <= last_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_real   = rsp_real_ff;
   assign rsp_imag   = rsp_imag_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

   always_comb begin
      stat.kind        = kind_type'(kind_ff);
      stat.last        = last_ff;
      stat.record_open = open_ff;
      stat.fact_ok     = (chk_status == STAT_OK);
      stat.sum_pos     = sum_pos;
      stat.sweep_done  = (sweep_ff == AW'(TABLE_SIZE - 1));
      stat.div_done    = div_done;
      stat.sqrt_done   = sqrt_done;
      stat.out_free    = !rsp_valid_ff || rsp_ready;
   end

endmodule

// ----- hw/rtl/vapn_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vapn_ctrl
// Sequencer for one request at a time.
// ----------------------------------------------------------------------------
module vapn_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  vapn_pkg::stat_type  stat,
   output vapn_pkg::cmd_type   cmd
);
   import vapn_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (stat.kind)
               KIND_MAP_RESET: begin
                  cmd.map_reset = 1'b1;
                  state_in = ST_IDLE;
               end
               KIND_MAP_ENTRY: begin
                  cmd.map_write = 1'b1;
                  state_in = ST_IDLE;
               end
               KIND_POWER_CLEAR: begin
                  cmd.power_clear = 1'b1;
                  state_in = ST_CLEAR;
               end
               KIND_SURVEY: begin
                  cmd.accumulate = 1'b1;
                  state_in = stat.last ? ST_MEAN_START : ST_IDLE;
               end
               KIND_SCALE: begin
                  state_in = stat.record_open ? ST_SCALE : ST_FACT_CHECK;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_FACT_CHECK: begin
            cmd.fact_check = 1'b1;
            state_in = stat.fact_ok ? ST_FACT_MUL : ST_SCALE;
         end
         ST_FACT_MUL: begin
            cmd.fact_mul = 1'b1;
            state_in = ST_FACT_START;
         end
         ST_FACT_START: begin
            cmd.div_start = 1'b1;
            state_in = ST_FACT_DIV;
         end
         ST_FACT_DIV: begin
            if (stat.div_done) begin
               cmd.fact_store = 1'b1;
               state_in = ST_SCALE;
            end
         end
         ST_MEAN_START: begin
            cmd.div_sel_mean = 1'b1;
            if (stat.sum_pos) begin
               cmd.div_start = 1'b1;
               state_in = ST_MEAN_DIV;
            end else begin
               cmd.surv_write = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_MEAN_DIV: begin
            if (stat.div_done) begin
               cmd.sqrt_start = 1'b1;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (stat.sqrt_done) begin
               cmd.surv_write = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SCALE: begin
            cmd.scale_mul = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ----- hw/rtl/vapn_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vapn_checker
// Port-level checks for the visibility power normaliser.
// ----------------------------------------------------------------------------
module vapn_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [vapn_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input logic [vapn_pkg::STATUS_W-1:0]      rsp_tuser,
   input logic                               rsp_tlast
);

   // one request at a time
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted back to back");

   // table sweep after reset
   a_sweep_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("not busy after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

endmodule

bind visibility_auto_power_normalizer vapn_checker u_vapn_checker (.*);

// ----- test/visibility_auto_power_normalizer_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// visibility_auto_power_normalizer_checker
// Watches both channels of the power normaliser. For each accepted request it
// updates its own copy of the power table, frequency map and record state, and
// queues the expected scaled point. Each accepted response is compared with
// the oldest queued point, field by field.
// ----------------------------------------------------------------------------
module visibility_auto_power_normalizer_checker #(
   parameter int ANTENNAS   = 32,
   parameter int FREQS      = 32,
   parameter int MAX_POINTS = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [vapn_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [vapn_pkg::KIND_W-1:0]     req_tuser,
   input  logic                            req_tlast,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [vapn_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [vapn_pkg::STATUS_W-1:0]   rsp_tuser,
   input  logic                            rsp_tlast,
   output int                              fail_count,
   output int                              pending,
   output int                              request_count,
   output int                              point_count_seen
);
   import vapn_pkg::*;

   localparam int SLOTS = ANTENNAS * FREQS * 4;

   typedef struct {
      logic [31:0] re;
      logic [31:0] im;
      status_type  status;
      logic        last;
   } point_type;

   point_type   expected_points[$];
   logic [31:0] power_mem[SLOTS];
   logic        power_ok[SLOTS];
   logic [4:0]  fmap[32];
   longint      sum_acc;
   int unsigned sum_count;
   logic [31:0] factor;
   logic        in_record;
   status_type  rec_status;

   assign pending = expected_points.size();

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic int pol_index(input logic [7:0] c);
      int p;
      p = 4;
      if (c == POL_L) p = 0;
      else if (c == POL_R) p = 1;
      else if (c == POL_X) p = 2;
      else if (c == POL_Y) p = 3;
      return p;
   endfunction

   function automatic int slot_index(input logic [7:0] ant, input int pol, input logic [4:0] fi);
      int f;
      f = fmap[fi];
      if (ant < 1 || ant > ANTENNAS || f >= FREQS) return -1;
      return ((ant - 1) * FREQS + f) * 4 + pol;
   endfunction

   function automatic logic [31:0] int_sqrt(input logic [63:0] v);
      logic [63:0] res, probe;
      res = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
         if (v >= res + probe) begin
            v = v - (res + probe);
            res = (res >> 1) + probe;
         end else begin
            res >>= 1;
         end
         probe >>= 2;
      end
      return res[31:0];
   endfunction

   function automatic logic [31:0] scaled(input logic [31:0] raw, input logic [31:0] fac);
      longint p, q;
      p = longint'($signed(raw)) * longint'({32'd0, fac});
      q = p / 65536;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q[31:0];
   endfunction

   task automatic open_record(input logic [15:0] bl, input logic [7:0] rp, input logic [7:0] mp,
                              input logic [4:0] fi);
      int pr, pm, sr, sm;
      logic [63:0] prod, quot;
      pr = pol_index(rp);
      pm = pol_index(mp);
      factor = ONE_Q16;
      if (pr > 3 || pm > 3) begin
         rec_status = STAT_BAD_POL;
         return;
      end
      sr = slot_index(bl[15:8], pr, fi);
      sm = slot_index(bl[7:0], pm, fi);
      if (sr < 0 || sm < 0) begin
         rec_status = STAT_BAD_ANT;
         return;
      end
      if (!power_ok[sr] || !power_ok[sm] || power_mem[sr] == 0 || power_mem[sm] == 0) begin
         rec_status = STAT_NO_POWER;
         return;
      end
      prod = {32'd0, power_mem[sr]} * {32'd0, power_mem[sm]};
      quot = (64'd1 << 48) / prod;
      factor = (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
      rec_status = STAT_OK;
   endtask

   task automatic close_survey(input logic [15:0] bl, input logic [7:0] rp, input logic [7:0] mp,
                               input logic [4:0] fi);
      int pol, s;
      logic [63:0] mean;
      logic [31:0] pw;
      pol = pol_index(rp);
      if (bl[15:8] == bl[7:0] && rp == mp && pol < 4) begin
         s = slot_index(bl[15:8], pol, fi);
         if (s >= 0) begin
            pw = 0;
            if (sum_acc > 0 && sum_count > 0) begin
               mean = 64'(sum_acc) / 64'(sum_count);
               pw = int_sqrt(mean << 16);
            end
            power_mem[s] = pw;
            power_ok[s] = 1'b1;
         end
      end
      sum_acc = 0;
      sum_count = 0;
   endtask

   task automatic take_request();
      logic [15:0] bl;
      logic [7:0]  rp, mp;
      logic [4:0]  fi, pf;
      logic [31:0] re, im;
      point_type   pt;
      bl = req_tdata[15:0];
      rp = req_tdata[23:16];
      mp = req_tdata[31:24];
      fi = req_tdata[36:32];
      pf = req_tdata[41:37];
      re = req_tdata[73:42];
      im = req_tdata[105:74];
      request_count++;
      case (req_tuser)
         KIND_MAP_RESET:
            for (int i = 0; i < 32; i++) fmap[i] = 5'(i);
         KIND_MAP_ENTRY:
            if (fi < pf) fmap[pf] = fi;
            else if (pf < fi) fmap[fi] = pf;
         KIND_POWER_CLEAR: begin
            for (int i = 0; i < SLOTS; i++) power_ok[i] = 1'b0;
            sum_acc = 0;
            sum_count = 0;
            in_record = 1'b0;
         end
         KIND_SURVEY: begin
            if (sum_count < MAX_POINTS) begin
               sum_acc += longint'($signed(re));
               sum_count++;
            end
            if (req_tlast) close_survey(bl, rp, mp, fi);
         end
         KIND_SCALE: begin
            if (!in_record) begin
               open_record(bl, rp, mp, fi);
               in_record = 1'b1;
            end
            pt.re = scaled(re, factor);
            pt.im = scaled(im, factor);
            pt.status = rec_status;
            pt.last = req_tlast;
            expected_points.push_back(pt);
            if (req_tlast) in_record = 1'b0;
         end
         default: ;
      endcase
   endtask

   initial begin
      fail_count = 0;
      request_count = 0;
      point_count_seen = 0;
      for (int i = 0; i < SLOTS; i++) begin
         power_mem[i] = 0;
         power_ok[i] = 1'b0;
      end
      for (int i = 0; i < 32; i++) fmap[i] = 5'(i);
      sum_acc = 0;
      sum_count = 0;
      factor = 0;
      in_record = 1'b0;
      rec_status = STAT_OK;
   end

   always @(posedge clock) begin
      point_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) take_request();
         if (rsp_tvalid && rsp_tready) begin
            point_count_seen++;
            if (expected_points.size() == 0) begin
               report("unexpected response", rsp_tdata, 0);
            end else begin
               want = expected_points.pop_front();
               if (rsp_tdata[31:0] !== want.re) report("scaled_real", rsp_tdata[31:0], want.re);
               if (rsp_tdata[63:32] !== want.im) report("scaled_imag", rsp_tdata[63:32], want.im);
               if (rsp_tuser !== want.status) report("status", rsp_tuser, want.status);
               if (rsp_tlast !== want.last) report("last_of_record", rsp_tlast, want.last);
            end
         end
      end
   end

endmodule

// ----- test/visibility_auto_power_normalizer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// visibility_auto_power_normalizer_tb
// Drives survey, scale, map and clear requests into the power normaliser with
// random gaps and response stalls, and takes the verdict from the checker.
// ----------------------------------------------------------------------------
module visibility_auto_power_normalizer_tb;
   import vapn_pkg::*;

   localparam int ANT_LIMIT = 32;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [KIND_W-1:0]     req_tuser;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  rsp_tlast;
   int                    fail_count, pending, request_count, point_count_seen;
   int                    sent;
   logic                  send_quiet;

   visibility_auto_power_normalizer dut (.*);

   visibility_auto_power_normalizer_checker chk (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast,
      .fail_count, .pending, .request_count, .point_count_seen
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("[visibility_auto_power_normalizer] ERROR");
      $finish;
   end

   task automatic send(input logic [2:0] kind, input logic [15:0] bl, input logic [7:0] rp,
                       input logic [7:0] mp, input logic [4:0] fi, input logic [4:0] pf,
                       input logic [31:0] re, input logic [31:0] im, input logic last);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = kind;
      req_tlast = last;
      req_tdata = {6'd0, im, re, pf, fi, mp, rp, bl};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      sent++;
      if (sent % 64 == 0) send_quiet = ~send_quiet;
   endtask

   function automatic logic [7:0] pick_ant();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 8'd0;
      if (r == 1) return 8'($urandom_range(ANT_LIMIT + 1, 255));
      return 8'($urandom_range(1, 6));
   endfunction

   function automatic logic [7:0] pick_pol();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 8'($urandom);
      case (r % 4)
         0: return POL_L;
         1: return POL_R;
         2: return POL_X;
         default: return POL_Y;
      endcase
   endfunction

   task automatic survey_record(input logic [7:0] ant, input logic [7:0] pol, input logic [4:0] fi,
                                input int n, input logic neg);
      logic [31:0] v;
      for (int i = 0; i < n; i++) begin
         v = neg ? $urandom : $urandom_range(0, 32'h1000_0000);
         send(KIND_SURVEY, {ant, ant}, pol, pol, fi, 5'($urandom), v, $urandom, i == n - 1);
      end
   endtask

   task automatic scale_record(input logic [15:0] bl, input logic [7:0] rp, input logic [7:0] mp,
                               input logic [4:0] fi, input int n);
      for (int i = 0; i < n; i++)
         send(KIND_SCALE, bl, rp, mp, fi, 5'($urandom), $urandom, $urandom, i == n - 1);
   endtask

   // response side, with one long hold-off to back the block up
   initial begin
      int gap, taken;
      logic quiet, stalled;
      taken = 0;
      quiet = 1'b0;
      stalled = 1'b0;
      rsp_tready = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         gap = quiet ? 0 : $urandom_range(0, 7);
         if (taken == 150 && !stalled) begin
            gap = 400;
            stalled = 1'b1;
         end
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
         if (taken % 50 == 0) quiet = ~quiet;
         @(negedge clock);
      end
   end

   initial begin
      int r;
      logic [7:0] a, b;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      req_tlast = 1'b0;
      sent = 0;
      send_quiet = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed
      send(KIND_MAP_ENTRY, 0, 0, 0, 5'd3, 5'd3, 0, 0, 0);
      send(KIND_MAP_ENTRY, 0, 0, 0, 5'd31, 5'd2, 0, 0, 0);
      send(KIND_MAP_ENTRY, 0, 0, 0, 5'd1, 5'd4, 0, 0, 0);
      survey_record(8'd1, POL_L, 5'd2, 2, 1'b0);
      survey_record(8'd32, POL_Y, 5'd31, 2, 1'b0);
      survey_record(8'd2, POL_R, 5'd0, 1, 1'b0);
      send(KIND_SURVEY, 16'h0303, POL_X, POL_X, 5'd0, 0, 32'h8000_0000, 0, 1);
      send(KIND_SCALE, 16'h0120, POL_L, POL_Y, 5'd31, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0);
      send(KIND_SCALE, 16'h0120, POL_L, POL_Y, 5'd31, 0, 32'h0001_0000, 32'hFFFF_FFFF, 1);
      scale_record(16'h0303, POL_X, POL_X, 5'd0, 1);
      scale_record(16'h0101, 8'h41, POL_L, 5'd2, 1);
      scale_record(16'h0101, POL_L, 8'hFF, 5'd2, 1);
      scale_record(16'h0001, POL_L, POL_L, 5'd2, 1);
      scale_record(16'h2101, POL_L, POL_L, 5'd2, 1);
      scale_record(16'h0202, POL_L, POL_L, 5'd0, 1);
      send(KIND_MAP_RESET, 0, 0, 0, 0, 0, 0, 0, 0);
      send(3'd5, 16'hFFFF, 8'hFF, 8'hFF, 5'd31, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
      send(3'd7, 0, 0, 0, 0, 0, 0, 0, 0);
      send(KIND_POWER_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
      scale_record(16'h0120, POL_L, POL_Y, 5'd31, 1);

      // long survey record, gaps off at the start (send toggles them every 64 requests)
      send_quiet = 1'b1;
      survey_record(8'd4, POL_R, 5'd5, 200, 1'b0);
      send_quiet = 1'b0;
      scale_record(16'h0404, POL_R, POL_R, 5'd5, 2);

      // random
      while (sent < 1100) begin
         if (sent > 900 && sent < 920) begin
            req_tvalid = 1'b0;
            wait (pending == 0);
            repeat (100) @(negedge clock);
         end
         r = $urandom_range(0, 99);
         a = pick_ant();
         b = pick_ant();
         if (r < 40)
            survey_record(r < 36 ? a : 8'($urandom_range(1, 6)), pick_pol(), 5'($urandom),
                          $urandom_range(1, 6), r < 4);
         else if (r < 80)
            scale_record({a, b}, pick_pol(), pick_pol(), 5'($urandom), $urandom_range(1, 8));
         else if (r < 88)
            send(KIND_MAP_ENTRY, 16'($urandom), 8'($urandom), 8'($urandom), 5'($urandom),
                 5'($urandom), $urandom, $urandom, 1'($urandom));
         else if (r < 90)
            send(KIND_MAP_RESET, 16'($urandom), 8'($urandom), 8'($urandom), 5'($urandom),
                 5'($urandom), $urandom, $urandom, 1'($urandom));
         else if (r < 91)
            send(KIND_POWER_CLEAR, 16'($urandom), 8'($urandom), 8'($urandom), 5'($urandom),
                 5'($urandom), $urandom, $urandom, 1'($urandom));
         else
            send(3'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), 5'($urandom),
                 5'($urandom), $urandom, $urandom, 1'($urandom));
      end

      req_tvalid = 1'b0;
      wait (pending == 0);
      repeat (200) @(posedge clock);
      $display("%0d requests sent, %0d scaled points checked", request_count, point_count_seen);
      $display("covered map edits, power clears, long surveys and all four status codes");
      if (fail_count == 0) begin
         $display("[visibility_auto_power_normalizer] OK");
      end else begin
         $display("[visibility_auto_power_normalizer] ERROR");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/vapn_pkg.sv
hw/rtl/vapn_divider.sv
hw/rtl/vapn_sqrt.sv
hw/rtl/vapn_datapath.sv
hw/rtl/vapn_ctrl.sv
hw/rtl/visibility_auto_power_normalizer.sv
hw/rtl/vapn_checker.sv
test/visibility_auto_power_normalizer_checker.sv
test/visibility_auto_power_normalizer_tb.sv
